[src/encoder_angle_tracking_pll_top_defines.svh]
// ----------------------------------------------------------------------------
// Encoder angle tracking PLL assertion macros
// Shared concurrent assertion helpers for the tracker RTL.
// ----------------------------------------------------------------------------
`ifndef ENCODER_ANGLE_TRACKING_PLL_TOP_DEFINES_SVH
`define ENCODER_ANGLE_TRACKING_PLL_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define EATP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define EATP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define EATP_ASSERT(lbl, prop, msg)
`define EATP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[src/eatp_pkg.sv]
// ----------------------------------------------------------------------------
// Encoder angle tracking PLL package
// Register indexes, sequencer states and operation codes.
// ----------------------------------------------------------------------------
`default_nettype none
package eatp_pkg;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] RegCounts = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKi = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKp = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFmax = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPeriod = 3'd4;
  localparam logic [CfgIdxW-1:0] RegAlpha = 3'd5;
  localparam int unsigned MulBW = 34;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHK,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    OP_KI,
    OP_PER,
    OP_KP,
    OP_LPF
  } op_e;
endpackage
`default_nettype wire

[src/eatp_if.sv]
// ----------------------------------------------------------------------------
// Encoder angle tracking PLL channels
// Valid/ready channels for the count items and the result items.
// ----------------------------------------------------------------------------
`default_nettype none
interface eatp_in_if #(parameter int unsigned COUNT_WIDTH = 16);
  logic                   valid;
  logic                   ready;
  logic [COUNT_WIDTH-1:0] position_count;
  logic                   calibrated;
  modport source (output valid, position_count, calibrated, input ready);
  modport sink (input valid, position_count, calibrated, output ready);
endinterface

interface eatp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] speed_rpm;
  logic [31:0]        tracked_angle;
  logic               locked_valid;
  modport source (output valid, speed_rpm, tracked_angle, locked_valid, input ready);
  modport sink (input valid, speed_rpm, tracked_angle, locked_valid, output ready);
endinterface
`default_nettype wire

[src/encoder_angle_tracking_pll_top.sv]
// ----------------------------------------------------------------------------
// Encoder angle tracking PLL
// PI phase-locked observer with a bit-serial divider and shift-add multiplier.
// ----------------------------------------------------------------------------
// A tracking item runs a bit-serial division of a COUNT_WIDTH + 32 bit dividend,
// a check step, four 34-bit shift-add multiplies each with an update step, and
// an output step. A seeding item skips the multiplies; a disabled item goes
// straight to the output step. A stalled output delays the result load.
// The next item is accepted in the cycle after its result is loaded.
// Reset clears the tracker state and loads the register defaults.
`default_nettype none
`include "encoder_angle_tracking_pll_top_defines.svh"
module encoder_angle_tracking_pll_top #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  eatp_in_if.sink                          in_ch_i,
  eatp_out_if.source                       out_ch_o,
  input  wire                              cfg_we_i,
  input  wire [eatp_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire [eatp_pkg::CfgDataW-1:0]     cfg_data_i
);
  localparam int unsigned DvdW = COUNT_WIDTH + 32;
  localparam int unsigned CntW = $clog2(DvdW);
  localparam logic [CntW-1:0] MulLast = CntW'(eatp_pkg::MulBW - 1);
  localparam logic [CntW-1:0] DivLast = CntW'(DvdW - 1);

  logic [16:0] counts_q;
  logic [31:0] ki_q, period_q;
  logic [15:0] kp_q, alpha_q;
  logic [25:0] fmax_q;

  eatp_pkg::state_e state_q, state_d;
  eatp_pkg::op_e    op_q, op_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DvdW-1:0]  dvd_q, dvd_d;
  logic [16:0]      rem_q, rem_d;
  logic [31:0]      mul_a_q, mul_a_d;
  logic [eatp_pkg::MulBW-1:0] mul_b_q, mul_b_d;
  logic [65:0]      acc_q, acc_d;
  logic             neg_q, neg_d;
  logic signed [33:0] err_q, err_d;
  logic [31:0]      angle_q, angle_d, step_q, step_d;
  logic signed [31:0] freq_q, freq_d, filt_q, filt_d;
  logic             valid_q, valid_d;
  logic             out_v_q, out_v_d;
  logic signed [31:0] o_speed_q;
  logic [31:0]      o_angle_q;
  logic             o_lock_q, o_load;

  logic [17:0] rem2;
  logic        ge;
  logic signed [33:0] dif, errw;
  logic [65:0] accr32, accr16;
  logic [49:0] mag;
  logic signed [50:0] sr, fsum, lsum;
  logic signed [31:0] fnew;
  logic signed [35:0] f36, rpm, ldiff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counts_q <= 17'd16384;
      ki_q <= 32'd65536;
      kp_q <= 16'd3277;
      fmax_q <= 26'd32768000;
      period_q <= 32'd429497;
      alpha_q <= 16'd6554;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        eatp_pkg::RegCounts: counts_q <= cfg_data_i[16:0];
        eatp_pkg::RegKi: ki_q <= cfg_data_i;
        eatp_pkg::RegKp: kp_q <= cfg_data_i[15:0];
        eatp_pkg::RegFmax: fmax_q <= cfg_data_i[25:0];
        eatp_pkg::RegPeriod: period_q <= cfg_data_i;
        eatp_pkg::RegAlpha: alpha_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign in_ch_i.ready = (state_q == eatp_pkg::ST_IDLE);

  always_comb begin
    rem2 = {rem_q, dvd_q[DvdW-1]};
    ge = (rem2 >= {1'b0, counts_q});
    dif = $signed({2'b00, dvd_q[31:0]}) - $signed({2'b00, angle_q});
    if (dif > 34'sd2147483648) begin
      errw = dif - 34'sd4294967296;
    end else if (dif < -34'sd2147483648) begin
      errw = dif + 34'sd4294967296;
    end else begin
      errw = dif;
    end
    accr32 = acc_q + (66'd1 << 31);
    accr16 = acc_q + (66'd1 << 15);
    mag = (op_q == eatp_pkg::OP_KI) ? {16'd0, accr32[65:32]} : accr16[65:16];
    sr = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    fsum = sr + 51'(freq_q);
    if (fsum > $signed({25'd0, fmax_q})) begin
      fnew = $signed({6'd0, fmax_q});
    end else if (fsum < -$signed({25'd0, fmax_q})) begin
      fnew = -$signed({6'd0, fmax_q});
    end else begin
      fnew = fsum[31:0];
    end
    f36 = 36'(freq_q);
    rpm = (f36 <<< 6) - (f36 <<< 2);
    ldiff = rpm - 36'(filt_q);
    lsum = sr + 51'(filt_q);
  end

  always_comb begin
    state_d = state_q;
    op_d = op_q;
    cnt_d = cnt_q;
    dvd_d = dvd_q;
    rem_d = rem_q;
    mul_a_d = mul_a_q;
    mul_b_d = mul_b_q;
    acc_d = acc_q;
    neg_d = neg_q;
    err_d = err_q;
    angle_d = angle_q;
    step_d = step_q;
    freq_d = freq_q;
    filt_d = filt_q;
    valid_d = valid_q;
    out_v_d = out_v_q;
    o_load = 1'b0;
    if (out_ch_o.ready) begin
      out_v_d = 1'b0;
    end
    unique case (state_q)
      eatp_pkg::ST_IDLE: begin
        if (in_ch_i.valid) begin
          if (!in_ch_i.calibrated || counts_q <= 17'd1) begin
            angle_d = '0;
            freq_d = '0;
            filt_d = '0;
            valid_d = 1'b0;
            state_d = eatp_pkg::ST_OUT;
          end else begin
            dvd_d = {in_ch_i.position_count, 32'd0};
            rem_d = '0;
            cnt_d = DivLast;
            state_d = eatp_pkg::ST_DIV;
          end
        end
      end
      eatp_pkg::ST_DIV: begin
        rem_d = ge ? 17'(rem2 - {1'b0, counts_q}) : rem2[16:0];
        dvd_d = {dvd_q[DvdW-2:0], ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = eatp_pkg::ST_CHK;
        end
      end
      eatp_pkg::ST_CHK: begin
        if (!valid_q) begin
          angle_d = dvd_q[31:0];
          freq_d = '0;
          filt_d = '0;
          valid_d = 1'b1;
          state_d = eatp_pkg::ST_OUT;
        end else begin
          err_d = errw;
          op_d = eatp_pkg::OP_KI;
          mul_a_d = ki_q;
          neg_d = errw[33];
          mul_b_d = errw[33] ? 34'(-errw) : 34'(errw);
          acc_d = '0;
          cnt_d = MulLast;
          state_d = eatp_pkg::ST_MUL;
        end
      end
      eatp_pkg::ST_MUL: begin
        acc_d = {acc_q[64:0], 1'b0} +
                (mul_b_q[eatp_pkg::MulBW-1] ? {34'd0, mul_a_q} : 66'd0);
        mul_b_d = {mul_b_q[eatp_pkg::MulBW-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = eatp_pkg::ST_ACC;
        end
      end
      eatp_pkg::ST_ACC: begin
        acc_d = '0;
        cnt_d = MulLast;
        state_d = eatp_pkg::ST_MUL;
        case (op_q)
          eatp_pkg::OP_KI: begin
            freq_d = fnew;
            op_d = eatp_pkg::OP_PER;
            mul_a_d = period_q;
            neg_d = fnew[31];
            mul_b_d = {2'b00, fnew[31] ? -fnew : fnew};
          end
          eatp_pkg::OP_PER: begin
            step_d = sr[31:0];
            op_d = eatp_pkg::OP_KP;
            mul_a_d = {16'd0, kp_q};
            neg_d = err_q[33];
            mul_b_d = err_q[33] ? 34'(-err_q) : 34'(err_q);
          end
          eatp_pkg::OP_KP: begin
            angle_d = angle_q + step_q + sr[31:0];
            op_d = eatp_pkg::OP_LPF;
            mul_a_d = {16'd0, alpha_q};
            neg_d = ldiff[35];
            mul_b_d = ldiff[35] ? 34'(-ldiff) : ldiff[33:0];
          end
          default: begin
            if (lsum > 51'sd2147483647) begin
              filt_d = 32'sh7fffffff;
            end else if (lsum < -51'sd2147483648) begin
              filt_d = 32'sh80000000;
            end else begin
              filt_d = lsum[31:0];
            end
            state_d = eatp_pkg::ST_OUT;
          end
        endcase
      end
      eatp_pkg::ST_OUT: begin
        if (!out_v_q || out_ch_o.ready) begin
          o_load = 1'b1;
          out_v_d = 1'b1;
          state_d = eatp_pkg::ST_IDLE;
        end
      end
      default: state_d = eatp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= eatp_pkg::ST_IDLE;
      op_q <= eatp_pkg::OP_KI;
      cnt_q <= '0;
      angle_q <= '0;
      freq_q <= '0;
      filt_q <= '0;
      valid_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q <= op_d;
      cnt_q <= cnt_d;
      angle_q <= angle_d;
      freq_q <= freq_d;
      filt_q <= filt_d;
      valid_q <= valid_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    mul_a_q <= mul_a_d;
    mul_b_q <= mul_b_d;
    acc_q <= acc_d;
    neg_q <= neg_d;
    err_q <= err_d;
    step_q <= step_d;
    if (o_load) begin
      o_speed_q <= filt_q;
      o_angle_q <= angle_q;
      o_lock_q <= valid_q;
    end
  end

  assign out_ch_o.valid = out_v_q;
  assign out_ch_o.speed_rpm = o_speed_q;
  assign out_ch_o.tracked_angle = o_angle_q;
  assign out_ch_o.locked_valid = o_lock_q;

  `EATP_ASSERT(a_unlocked_zero, (out_ch_o.valid && !out_ch_o.locked_valid) |-> (out_ch_o.speed_rpm == 0 && out_ch_o.tracked_angle == 0), "Unlocked result is not zero.")
  `EATP_ASSERT(a_busy_after_accept, (in_ch_i.valid && in_ch_i.ready) |=> !in_ch_i.ready, "Input accepted while busy.")
  `EATP_ASSERT_ALWAYS(a_mul_count, (state_q == eatp_pkg::ST_MUL) |-> (cnt_q <= MulLast), "Multiplier count out of range.")
endmodule
`default_nettype wire

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// Encoder angle tracking PLL testbench
// Drives count items with random gaps, predicts each result item from a
// bit-accurate model of the tracking loop, and checks results in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  typedef struct packed {
    logic signed [31:0] speed_rpm;
    logic [31:0]        tracked_angle;
    logic               locked_valid;
  } track_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [eatp_pkg::CfgIdxW-1:0] cfg_idx_i = eatp_pkg::RegCounts;
  logic [eatp_pkg::CfgDataW-1:0] cfg_data_i = '0;

  eatp_in_if #(.COUNT_WIDTH(16)) in_ch ();
  eatp_out_if out_ch ();

  encoder_angle_tracking_pll_top #(.COUNT_WIDTH(16)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_ch_i(in_ch),
    .out_ch_o(out_ch),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  logic [16:0] m_counts;
  logic [31:0] m_ki, m_period, m_fmax;
  logic [15:0] m_kp, m_alpha;
  logic [31:0] m_angle;
  longint m_freq, m_filt;
  bit m_valid;
  track_res_t pending_results[$];
  int errors = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.position_count = '0;
    in_ch.calibrated = 1'b0;
    out_ch.ready = 1'b0;
  end

  function automatic longint round_mul(longint unsigned a, longint b, int s);
    longint unsigned mag, p;
    mag = (b < 0) ? longint'(-b) : longint'(b);
    p = (a * mag + (64'd1 << (s - 1))) >> s;
    return (b < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic track_res_t track_step(logic [15:0] pos, logic cal);
    track_res_t r;
    logic [31:0] meas;
    longint err, f, step, filt;
    logic [63:0] num;
    r = '0;
    if (!cal || m_counts <= 1) begin
      m_angle = '0; m_freq = 0; m_filt = 0; m_valid = 1'b0;
      return r;
    end
    num = {16'd0, pos, 32'd0};
    meas = 32'(num / 64'(m_counts));
    r.locked_valid = 1'b1;
    if (!m_valid) begin
      m_angle = meas; m_freq = 0; m_filt = 0; m_valid = 1'b1;
      r.tracked_angle = meas;
      return r;
    end
    err = longint'(meas) - longint'(m_angle);
    if (err > (64'sd1 <<< 31)) err -= (64'sd1 <<< 32);
    else if (err < -(64'sd1 <<< 31)) err += (64'sd1 <<< 32);
    f = m_freq + round_mul(64'(m_ki), err, 32);
    if (f > longint'(m_fmax)) f = longint'(m_fmax);
    if (f < -longint'(m_fmax)) f = -longint'(m_fmax);
    m_freq = longint'(int'(f));
    step = round_mul(64'(m_period), f, 16) + round_mul(64'(m_kp), err, 16);
    m_angle = m_angle + 32'(step);
    filt = m_filt + round_mul(64'(m_alpha), f * 60 - m_filt, 16);
    if (filt > 64'sd2147483647) filt = 64'sd2147483647;
    if (filt < -64'sd2147483648) filt = -64'sd2147483648;
    m_filt = filt;
    r.speed_rpm = 32'(filt);
    r.tracked_angle = m_angle;
    return r;
  endfunction

  task automatic write_reg(logic [eatp_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      eatp_pkg::RegCounts: m_counts = val[16:0];
      eatp_pkg::RegKi: m_ki = val;
      eatp_pkg::RegKp: m_kp = val[15:0];
      eatp_pkg::RegFmax: m_fmax = {6'd0, val[25:0]};
      eatp_pkg::RegPeriod: m_period = val;
      eatp_pkg::RegAlpha: m_alpha = val[15:0];
      default: ;
    endcase
  endtask

  // Valid stays high after an accept until the next item or an idle phase
  // takes the channel over.
  task automatic send_count(logic [15:0] pos, logic cal);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.position_count <= pos;
    in_ch.calibrated <= cal;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_results.push_back(track_step(pos, cal));
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_config(logic [16:0] c, logic [31:0] ki, logic [15:0] kp,
                            logic [25:0] fm, logic [31:0] per, logic [15:0] al);
    drain_results();
    write_reg(eatp_pkg::RegCounts, 32'(c));
    write_reg(eatp_pkg::RegKi, ki);
    write_reg(eatp_pkg::RegKp, 32'(kp));
    write_reg(eatp_pkg::RegFmax, 32'(fm));
    write_reg(eatp_pkg::RegPeriod, per);
    write_reg(eatp_pkg::RegAlpha, 32'(al));
  endtask

  // Result checker; the receive side may hold ready low for a random wait before each item.
  initial begin
    track_res_t exp_r;
    int wait_n;
    forever begin
      wait_n = $urandom_range(0, 8);
      if (wait_n != 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result angle exp none got %h", $time,
                 out_ch.tracked_angle);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.speed_rpm !== exp_r.speed_rpm) begin
          $display("%0t speed_rpm exp %h got %h", $time, exp_r.speed_rpm,
                   out_ch.speed_rpm);
          errors++;
        end
        if (out_ch.tracked_angle !== exp_r.tracked_angle) begin
          $display("%0t tracked_angle exp %h got %h", $time,
                   exp_r.tracked_angle, out_ch.tracked_angle);
          errors++;
        end
        if (out_ch.locked_valid !== exp_r.locked_valid) begin
          $display("%0t locked_valid exp %b got %b", $time,
                   exp_r.locked_valid, out_ch.locked_valid);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_count(16'd0, 1'b1);
    send_count(16'd100, 1'b1);
    send_count(16'd16383, 1'b1);
    send_count(16'd8192, 1'b1);
    send_count(16'd0, 1'b1);
    send_count(16'hFFFF, 1'b1);
    send_count(16'd5, 1'b0);
    send_count(16'hFFFF, 1'b1);
    send_count(16'd8192, 1'b1);
    set_config(17'd65536, 32'hFFFFFFFF, 16'hFFFF, 26'd35791394, 32'hFFFFFFFF, 16'hFFFF);
    send_count(16'd0, 1'b1);
    send_count(16'd32768, 1'b1);
    send_count(16'd0, 1'b1);
    send_count(16'd32768, 1'b1);
    send_count(16'hFFFF, 1'b1);
    set_config(17'd1, 32'd0, 16'd0, 26'h3FFFFFF, 32'd0, 16'd0);
    send_count(16'd3, 1'b1);
    drain_results();
    write_reg(eatp_pkg::RegCounts, 32'd0);
    send_count(16'd7, 1'b1);
    set_config(17'd2, 32'd1000000, 16'd100, 26'h3FFFFFF, 32'd4000000, 16'd30000);
    send_count(16'd0, 1'b1);
    send_count(16'd1, 1'b1);
    send_count(16'd3, 1'b1);
    send_count(16'd0, 1'b1);
  endtask

  task automatic test_random(int n);
    logic [15:0] pos;
    logic [16:0] cpt;
    int vel;
    pos = 0;
    vel = $urandom_range(0, 400) - 200;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 199) == 0) begin
        cpt = ($urandom_range(0, 1)) ? 17'($urandom_range(2, 65536))
                                     : 17'($urandom_range(2, 4096));
        set_config(cpt, $urandom(), 16'($urandom()), 26'($urandom()),
                   ($urandom_range(0, 1)) ? $urandom() : 32'($urandom_range(0, 1000000)),
                   16'($urandom()));
        vel = $urandom_range(0, 400) - 200;
      end
      if ($urandom_range(0, 9) == 0) pos = 16'($urandom());
      else if (m_counts > 1) pos = 16'((int'(pos) + vel + int'(m_counts)) % int'(m_counts));
      send_count(pos, $urandom_range(0, 29) != 0);
    end
  endtask

  task automatic test_quiesce();
    drain_results();
    send_count(16'($urandom()), 1'b1);
    send_count(16'($urandom()), 1'b1);
  endtask

  initial begin
    m_counts = 17'd16384; m_ki = 32'd65536; m_kp = 16'd3277;
    m_fmax = 32'd32768000; m_period = 32'd429497; m_alpha = 16'd6554;
    m_angle = 0; m_freq = 0; m_filt = 0; m_valid = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(800);
    test_quiesce();
    set_config(17'd16384, 32'd65536, 16'd3277, 26'd32768000, 32'd429497, 16'd6554);
    test_random(800);
    drain_results();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire
